// File: design/burh_pkg.sv
// ============================================================================
// burh_pkg: shared definitions for the bounded undo/redo history
// Mode and status codes, register indexes, sequencer states and the
// default values of the top-level parameters.
// ============================================================================
package burh_pkg;

    // Default sizes
    localparam int DEF_HISTORY_DEPTH = 16;
    localparam int DEF_STATE_BITS    = 32;

    // Fixed field widths
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int CAP_W    = 5;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Operation codes carried on the mode field
    localparam logic [MODE_W-1:0] MODE_COMMIT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNDO       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REDO       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_UNDO  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REDO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESTART    = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAILED    = 2'd2;

    // Configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_START    = 1'b1;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Sequencer states
    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } seq_state_t;

endpackage

// File: design/bounded_undo_redo_history.sv
// ============================================================================
// bounded_undo_redo_history: current state word with undo and redo stacks
// Two ring buffers in synchronous memories hold the histories; a two-state
// sequencer reads the top entry, then updates the rings and current state.
// ============================================================================
// An item runs as follows: start is taken when busy is low, busy is
// high for the following cycle while the item executes, and the result beat
// is marked by done in the cycle after that, so a new start can be taken in
// that same cycle. This timing is set by the read latency of the
// history memories: the entry to pop or peek is read on the accepting edge
// and used on the next. The receiver cannot stall: status and peek_value are
// valid only while done is high, whereas current_state and the two depth
// outputs always show the state after the last completed item. Both stacks
// come up empty out of reset with no clearing pass. Configuration writes are
// taken in the same cycle; writing the capacity empties both histories.
// ============================================================================
module bounded_undo_redo_history
#(
    parameter int HISTORY_DEPTH = burh_pkg::DEF_HISTORY_DEPTH,
    parameter int STATE_BITS    = burh_pkg::DEF_STATE_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [burh_pkg::WORD_W-1:0]     cfg_wdata,
    // Command side
    input  logic                            start,
    output logic                            busy,
    input  logic [burh_pkg::MODE_W-1:0]     mode,
    input  logic [burh_pkg::WORD_W-1:0]     new_state,
    input  logic                            reduce_failed,
    input  logic [burh_pkg::INDEX_W-1:0]    history_index,
    // Result side
    output logic                            done,
    output logic [burh_pkg::STATUS_W-1:0]   status,
    output logic [burh_pkg::WORD_W-1:0]     current_state,
    output logic [burh_pkg::WORD_W-1:0]     peek_value,
    output logic [burh_pkg::COUNT_W-1:0]    undo_depth_out,
    output logic [burh_pkg::COUNT_W-1:0]    redo_depth_out
);

    import burh_pkg::*;

    localparam int DEPTH_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W   = DEPTH_W + 1;

    // Slot of the entry at position pos from the oldest, wrapping at cap.
    function automatic logic [SLOT_W-1:0] ring_slot
    (
        input logic [SLOT_W-1:0]  oldest,
        input logic [DEPTH_W-1:0] pos,
        input logic [DEPTH_W-1:0] cap
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(oldest) + SUM_W'(pos);
        if ((cap != '0) && (sum >= SUM_W'(cap)))
        begin
            sum = sum - SUM_W'(cap);
        end
        if (sum >= SUM_W'(HISTORY_DEPTH))
        begin
            sum = '0;
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Configuration registers
    logic [CAP_W-1:0]      cfg_capacity_reg;
    logic [WORD_W-1:0]     cfg_start_reg;

    // Sequencer and control state
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic                  done_reg;
    logic                  done_next;

    // Architectural state
    logic [STATE_BITS-1:0] current_reg;
    logic [STATE_BITS-1:0] current_next;
    logic [DEPTH_W-1:0]    undo_depth_reg;
    logic [DEPTH_W-1:0]    undo_depth_next;
    logic [DEPTH_W-1:0]    redo_depth_reg;
    logic [DEPTH_W-1:0]    redo_depth_next;
    logic [SLOT_W-1:0]     undo_oldest_reg;
    logic [SLOT_W-1:0]     undo_oldest_next;
    logic [SLOT_W-1:0]     redo_oldest_reg;
    logic [SLOT_W-1:0]     redo_oldest_next;

    // Latched command
    logic [MODE_W-1:0]     mode_reg;
    logic [STATE_BITS-1:0] new_state_reg;
    logic                  failed_reg;
    logic [INDEX_W-1:0]    index_reg;

    // Result registers
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [WORD_W-1:0]     peek_reg;
    logic [WORD_W-1:0]     peek_next;

    // History memories and their ports
    logic [STATE_BITS-1:0] undo_mem [HISTORY_DEPTH];
    logic [STATE_BITS-1:0] redo_mem [HISTORY_DEPTH];
    logic [STATE_BITS-1:0] undo_rdata_reg;
    logic [STATE_BITS-1:0] redo_rdata_reg;
    logic [SLOT_W-1:0]     undo_raddr;
    logic [SLOT_W-1:0]     redo_raddr;
    logic [DEPTH_W-1:0]    undo_rpos;
    logic [DEPTH_W-1:0]    redo_rpos;
    logic                  undo_we;
    logic [SLOT_W-1:0]     undo_waddr;
    logic                  redo_we;
    logic [SLOT_W-1:0]     redo_waddr;

    logic                  accept;
    logic [DEPTH_W-1:0]    eff_cap;

    assign accept = start && (state_reg == S_IDLE);

    // Capacity in force, saturated at the memory depth.
    always_comb
    begin
        if (int'(cfg_capacity_reg) > HISTORY_DEPTH)
        begin
            eff_cap = DEPTH_W'(HISTORY_DEPTH);
        end
        else
        begin
            eff_cap = DEPTH_W'(cfg_capacity_reg);
        end
    end

    // Read addresses: the top entry for a pop, or the entry counted back for a peek.
    always_comb
    begin
        undo_rpos = undo_depth_reg - DEPTH_W'(1);
        redo_rpos = redo_depth_reg - DEPTH_W'(1);
        if (mode == MODE_PEEK_UNDO)
        begin
            undo_rpos = undo_depth_reg - DEPTH_W'(1) - DEPTH_W'(history_index);
        end
        if (mode == MODE_PEEK_REDO)
        begin
            redo_rpos = redo_depth_reg - DEPTH_W'(1) - DEPTH_W'(history_index);
        end
        undo_raddr = ring_slot(undo_oldest_reg, undo_rpos, eff_cap);
        redo_raddr = ring_slot(redo_oldest_reg, redo_rpos, eff_cap);
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy      = 1'b0;
        done_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_EXEC:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Execution: ring updates, memory writes and the result of the item.
    always_comb
    begin
        current_next     = current_reg;
        undo_depth_next  = undo_depth_reg;
        redo_depth_next  = redo_depth_reg;
        undo_oldest_next = undo_oldest_reg;
        redo_oldest_next = redo_oldest_reg;
        status_next      = status_reg;
        peek_next        = peek_reg;
        undo_we          = 1'b0;
        undo_waddr       = undo_oldest_reg;
        redo_we          = 1'b0;
        redo_waddr       = redo_oldest_reg;

        // A capacity write empties both histories.
        if (cfg_we && (cfg_index == REG_CAPACITY))
        begin
            undo_depth_next  = '0;
            redo_depth_next  = '0;
            undo_oldest_next = '0;
            redo_oldest_next = '0;
        end

        if (state_reg == S_EXEC)
        begin
            status_next = ST_OK;
            peek_next   = '0;
            case (mode_reg)
                MODE_COMMIT:
                begin
                    if (failed_reg)
                    begin
                        status_next = ST_FAILED;
                    end
                    else
                    begin
                        // Push current onto undo, dropping the oldest when full.
                        if (eff_cap != '0)
                        begin
                            undo_we = 1'b1;
                            if (undo_depth_reg < eff_cap)
                            begin
                                undo_waddr = ring_slot(undo_oldest_reg, undo_depth_reg, eff_cap);
                                undo_depth_next = undo_depth_reg + DEPTH_W'(1);
                            end
                            else
                            begin
                                undo_waddr = ring_slot(undo_oldest_reg, '0, eff_cap);
                                undo_oldest_next =
                                    ring_slot(undo_oldest_reg, DEPTH_W'(1), eff_cap);
                                undo_depth_next = eff_cap;
                            end
                        end
                        current_next     = new_state_reg;
                        redo_depth_next  = '0;
                        redo_oldest_next = '0;
                    end
                end
                MODE_UNDO:
                begin
                    if (undo_depth_reg == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        // Push current onto redo, then take the undo top.
                        if (eff_cap != '0)
                        begin
                            redo_we = 1'b1;
                            if (redo_depth_reg < eff_cap)
                            begin
                                redo_waddr = ring_slot(redo_oldest_reg, redo_depth_reg, eff_cap);
                                redo_depth_next = redo_depth_reg + DEPTH_W'(1);
                            end
                            else
                            begin
                                redo_waddr = ring_slot(redo_oldest_reg, '0, eff_cap);
                                redo_oldest_next =
                                    ring_slot(redo_oldest_reg, DEPTH_W'(1), eff_cap);
                                redo_depth_next = eff_cap;
                            end
                        end
                        undo_depth_next = undo_depth_reg - DEPTH_W'(1);
                        current_next    = undo_rdata_reg;
                    end
                end
                MODE_REDO:
                begin
                    if (redo_depth_reg == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        // Push current onto undo, then take the redo top.
                        if (eff_cap != '0)
                        begin
                            undo_we = 1'b1;
                            if (undo_depth_reg < eff_cap)
                            begin
                                undo_waddr = ring_slot(undo_oldest_reg, undo_depth_reg, eff_cap);
                                undo_depth_next = undo_depth_reg + DEPTH_W'(1);
                            end
                            else
                            begin
                                undo_waddr = ring_slot(undo_oldest_reg, '0, eff_cap);
                                undo_oldest_next =
                                    ring_slot(undo_oldest_reg, DEPTH_W'(1), eff_cap);
                                undo_depth_next = eff_cap;
                            end
                        end
                        redo_depth_next = redo_depth_reg - DEPTH_W'(1);
                        current_next    = redo_rdata_reg;
                    end
                end
                MODE_CLEAR:
                begin
                    undo_depth_next  = '0;
                    redo_depth_next  = '0;
                    undo_oldest_next = '0;
                    redo_oldest_next = '0;
                end
                MODE_PEEK_UNDO:
                begin
                    if (int'(index_reg) >= int'(undo_depth_reg))
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        peek_next = WORD_W'(undo_rdata_reg);
                    end
                end
                MODE_PEEK_REDO:
                begin
                    if (int'(index_reg) >= int'(redo_depth_reg))
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        peek_next = WORD_W'(redo_rdata_reg);
                    end
                end
                MODE_RESTART:
                begin
                    current_next     = STATE_BITS'(cfg_start_reg);
                    undo_depth_next  = '0;
                    redo_depth_next  = '0;
                    undo_oldest_next = '0;
                    redo_oldest_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            done_reg         <= 1'b0;
            current_reg      <= '0;
            undo_depth_reg   <= '0;
            redo_depth_reg   <= '0;
            undo_oldest_reg  <= '0;
            redo_oldest_reg  <= '0;
            cfg_capacity_reg <= CAP_RESET;
            cfg_start_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            current_reg     <= current_next;
            undo_depth_reg  <= undo_depth_next;
            redo_depth_reg  <= redo_depth_next;
            undo_oldest_reg <= undo_oldest_next;
            redo_oldest_reg <= redo_oldest_next;
            if (cfg_we && (cfg_index == REG_CAPACITY))
            begin
                cfg_capacity_reg <= cfg_wdata[CAP_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_START))
            begin
                cfg_start_reg <= cfg_wdata;
            end
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            new_state_reg <= STATE_BITS'(new_state);
            failed_reg    <= reduce_failed;
            index_reg     <= history_index;
        end
        status_reg <= status_next;
        peek_reg   <= peek_next;
    end

    // Undo history memory.
    always_ff @(posedge clk)
    begin
        if (undo_we)
        begin
            undo_mem[undo_waddr] <= current_reg;
        end
        if (accept)
        begin
            undo_rdata_reg <= undo_mem[undo_raddr];
        end
    end

    // Redo history memory.
    always_ff @(posedge clk)
    begin
        if (redo_we)
        begin
            redo_mem[redo_waddr] <= current_reg;
        end
        if (accept)
        begin
            redo_rdata_reg <= redo_mem[redo_raddr];
        end
    end

    // Result ports
    assign done           = done_reg;
    assign status         = status_reg;
    assign peek_value     = peek_reg;
    assign current_state  = WORD_W'(current_reg);
    assign undo_depth_out = COUNT_W'(undo_depth_reg);
    assign redo_depth_out = COUNT_W'(redo_depth_reg);

endmodule

// File: design/burh_checker.sv
// ============================================================================
// burh_checker: port-level checks for the bounded undo/redo history
// Watches the command and result ports over time and is bound to the top.
// ============================================================================
module burh_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            done,
    input  logic [burh_pkg::STATUS_W-1:0]   status,
    input  logic [burh_pkg::WORD_W-1:0]     current_state,
    input  logic [burh_pkg::WORD_W-1:0]     peek_value,
    input  logic [burh_pkg::COUNT_W-1:0]    undo_depth_out,
    input  logic [burh_pkg::COUNT_W-1:0]    redo_depth_out
);

    import burh_pkg::*;

    // An accepted command occupies exactly one busy cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // A result beat always follows the busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    // A rejected commit leaves the state and both depths untouched.
    a_failed_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FAILED)) |->
            ($stable(current_state) && $stable(undo_depth_out) && $stable(redo_depth_out)))
        else $error("rejected commit changed the state");

    // A not-found answer changes nothing and reads back zero.
    a_not_found_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOT_FOUND)) |->
            ($stable(current_state) && (peek_value == '0)))
        else $error("not-found answer changed the state or returned data");

endmodule

bind bounded_undo_redo_history burh_checker u_burh_checker (.*);

// File: bench/bounded_undo_redo_history_test.sv
`timescale 1ns / 100ps
// ============================================================================
// bounded_undo_redo_history_test: self-checking bench for the undo/redo block
// Drives commit, undo, redo, clear, peek and restart commands through the
// start/busy handshake under several history capacities and start values.
// A local model of the two history rings works out each result beat, and
// every done beat is compared field by field with the oldest prediction.
// ============================================================================
module bounded_undo_redo_history_test;
    import burh_pkg::*;

    localparam int RING_SLOTS = DEF_HISTORY_DEPTH;
    localparam int UNDO_RING = 0;
    localparam int REDO_RING = 1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   current;
        logic [WORD_W-1:0]   peek;
        logic [COUNT_W-1:0]  undo_depth;
        logic [COUNT_W-1:0]  redo_depth;
    } outcome_t;

    // Block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = REG_CAPACITY;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [MODE_W-1:0]    mode = MODE_COMMIT;
    logic [WORD_W-1:0]    new_state = '0;
    logic                 reduce_failed = 1'b0;
    logic [INDEX_W-1:0]   history_index = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [WORD_W-1:0]    current_state;
    logic [WORD_W-1:0]    peek_value;
    logic [COUNT_W-1:0]   undo_depth_out;
    logic [COUNT_W-1:0]   redo_depth_out;

    // Model of the block's state
    logic [WORD_W-1:0]    model_current = '0;
    logic [WORD_W-1:0]    model_mem [2][RING_SLOTS];
    int                   model_depth [2] = '{0, 0};
    int                   model_oldest [2] = '{0, 0};
    int                   model_capacity = int'(CAP_RESET);
    logic [WORD_W-1:0]    model_start = '0;

    // Predicted beats not yet seen, and run bookkeeping
    outcome_t             pending_outcomes [$];
    int                   mismatches = 0;
    int                   commands_sent = 0;
    int                   beats_checked = 0;
    int                   register_writes = 0;
    int                   stall_cycles = 0;
    bit                   gaps_enabled = 1'b1;

    bounded_undo_redo_history dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model of the history rings
    // ------------------------------------------------------------------

    // Capacity in force, saturated at the physical ring size.
    function automatic int ring_capacity();
        return (model_capacity > RING_SLOTS) ? RING_SLOTS : model_capacity;
    endfunction

    function automatic int ring_slot(int ring, int pos, int cap);
        int s;
        s = model_oldest[ring] + pos;
        if (cap != 0 && s >= cap)
            s -= cap;
        return (s < RING_SLOTS) ? s : 0;
    endfunction

    function automatic void ring_empty(int ring);
        model_depth[ring] = 0;
        model_oldest[ring] = 0;
    endfunction

    // A push onto a full ring overwrites the oldest entry.
    function automatic void ring_push(int ring, logic [WORD_W-1:0] value);
        int cap;
        cap = ring_capacity();
        if (cap == 0)
            return;
        if (model_depth[ring] < cap)
        begin
            model_mem[ring][ring_slot(ring, model_depth[ring], cap)] = value;
            model_depth[ring]++;
        end
        else
        begin
            model_mem[ring][ring_slot(ring, 0, cap)] = value;
            model_oldest[ring] = ring_slot(ring, 1, cap);
            model_depth[ring] = cap;
        end
    endfunction

    function automatic logic [WORD_W-1:0] ring_pop(int ring);
        model_depth[ring]--;
        return model_mem[ring][ring_slot(ring, model_depth[ring], ring_capacity())];
    endfunction

    function automatic logic [STATUS_W-1:0] ring_peek(int ring, int index,
                                                      output logic [WORD_W-1:0] value);
        value = '0;
        if (index >= model_depth[ring])
            return ST_NOT_FOUND;
        value = model_mem[ring][ring_slot(ring, model_depth[ring] - 1 - index,
                                          ring_capacity())];
        return ST_OK;
    endfunction

    // Applies one command to the model and returns the beat it should give.
    function automatic outcome_t predict_outcome(logic [MODE_W-1:0] op,
                                                 logic [WORD_W-1:0] next_value,
                                                 logic fail_flag,
                                                 logic [INDEX_W-1:0] index);
        outcome_t r;
        logic [WORD_W-1:0] read_value;
        r = '0;
        r.status = ST_OK;
        case (op)
            MODE_COMMIT:
                if (fail_flag)
                    r.status = ST_FAILED;
                else
                begin
                    ring_push(UNDO_RING, model_current);
                    model_current = next_value;
                    ring_empty(REDO_RING);
                end
            MODE_UNDO:
                if (model_depth[UNDO_RING] == 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    ring_push(REDO_RING, model_current);
                    model_current = ring_pop(UNDO_RING);
                end
            MODE_REDO:
                if (model_depth[REDO_RING] == 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    ring_push(UNDO_RING, model_current);
                    model_current = ring_pop(REDO_RING);
                end
            MODE_CLEAR:
            begin
                ring_empty(UNDO_RING);
                ring_empty(REDO_RING);
            end
            MODE_PEEK_UNDO:
            begin
                r.status = ring_peek(UNDO_RING, int'(index), read_value);
                r.peek = read_value;
            end
            MODE_PEEK_REDO:
            begin
                r.status = ring_peek(REDO_RING, int'(index), read_value);
                r.peek = read_value;
            end
            MODE_RESTART:
            begin
                model_current = model_start;
                ring_empty(UNDO_RING);
                ring_empty(REDO_RING);
            end
            default:
                ;
        endcase
        r.current = model_current;
        r.undo_depth = COUNT_W'(model_depth[UNDO_RING]);
        r.redo_depth = COUNT_W'(model_depth[REDO_RING]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t: %s, got %h, expected %h", $time, what, got, want);
    endtask

    // Every done beat is taken at the edge that ends it.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result beat with nothing pending", 64'sd1, 64'sd0);
            else
            begin
                want = pending_outcomes.pop_front();
                beats_checked++;
                if (status !== want.status)
                    report_mismatch("status", longint'(status), longint'(want.status));
                if (current_state !== want.current)
                    report_mismatch("current_state", longint'(current_state),
                                    longint'(want.current));
                if (peek_value !== want.peek)
                    report_mismatch("peek_value", longint'(peek_value),
                                    longint'(want.peek));
                if (undo_depth_out !== want.undo_depth)
                    report_mismatch("undo_depth_out", longint'(undo_depth_out),
                                    longint'(want.undo_depth));
                if (redo_depth_out !== want.redo_depth)
                    report_mismatch("redo_depth_out", longint'(redo_depth_out),
                                    longint'(want.redo_depth));
            end
        end
    end

    // Ends the run when neither a command nor a result has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Presents one command, waits for it to be taken, then records its beat.
    task automatic send_command(logic [MODE_W-1:0] op, logic [WORD_W-1:0] next_value,
                                logic fail_flag, logic [INDEX_W-1:0] index);
        mode <= op;
        new_state <= next_value;
        reduce_failed <= fail_flag;
        history_index <= index;
        if (!start)
            start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_outcomes.push_back(predict_outcome(op, next_value, fail_flag, index));
        commands_sent++;
        if (gaps_enabled && $urandom_range(0, 99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Holds off new commands until every predicted beat has come back.
    task automatic settle_block();
        if (start)
            start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic index, logic [WORD_W-1:0] data);
        settle_block();
        cfg_index <= index;
        cfg_wdata <= data;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        register_writes++;
        if (index == REG_CAPACITY)
        begin
            model_capacity = int'(data[CAP_W-1:0]);
            ring_empty(UNDO_RING);
            ring_empty(REDO_RING);
        end
        else
            model_start = data;
    endtask

    // Capacity sits in the low bits; the upper bits carry noise.
    task automatic set_capacity(int cap);
        logic [WORD_W-1:0] data;
        data = $urandom();
        data[CAP_W-1:0] = CAP_W'(cap);
        write_register(REG_CAPACITY, data);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Undo, redo and both peeks on empty histories, plus the unused code.
    task automatic test_empty_history();
        send_command(MODE_UNDO, 32'hFFFF_FFFF, 1'b0, 4'd0);
        send_command(MODE_REDO, 32'h0, 1'b1, 4'd15);
        send_command(MODE_PEEK_UNDO, 32'h0, 1'b0, 4'd0);
        send_command(MODE_PEEK_REDO, 32'h0, 1'b0, 4'd15);
        send_command(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 4'd15);
    endtask

    // Commits at the extremes, a rejected commit, rollback, roll forward, a clear and a restart.
    task automatic test_commit_and_rollback();
        write_register(REG_START, 32'hFFFF_FFFF);
        send_command(MODE_COMMIT, 32'hFFFF_FFFF, 1'b0, 4'd0);
        send_command(MODE_COMMIT, 32'h0000_0000, 1'b0, 4'd15);
        send_command(MODE_COMMIT, 32'h5A5A_5A5A, 1'b1, 4'd0);
        send_command(MODE_PEEK_UNDO, 32'h0, 1'b0, 4'd1);
        send_command(MODE_PEEK_UNDO, 32'h0, 1'b0, 4'd2);
        send_command(MODE_UNDO, 32'h0, 1'b0, 4'd0);
        send_command(MODE_UNDO, 32'h0, 1'b0, 4'd0);
        send_command(MODE_PEEK_REDO, 32'h0, 1'b0, 4'd1);
        send_command(MODE_REDO, 32'h0, 1'b0, 4'd0);
        send_command(MODE_CLEAR, 32'h0, 1'b0, 4'd0);
        send_command(MODE_REDO, 32'h0, 1'b0, 4'd0);
        send_command(MODE_RESTART, 32'h1234_5678, 1'b0, 4'd0);
    endtask

    // Capacity of one, of zero, and above the ring size.
    task automatic test_capacity_edges();
        set_capacity(1);
        send_command(MODE_COMMIT, 32'hA5A5_A5A5, 1'b0, 4'd0);
        send_command(MODE_COMMIT, 32'h3C3C_3C3C, 1'b0, 4'd0);
        send_command(MODE_PEEK_UNDO, 32'h0, 1'b0, 4'd0);
        set_capacity(0);
        send_command(MODE_COMMIT, 32'h0F0F_0F0F, 1'b0, 4'd0);
        send_command(MODE_UNDO, 32'h0, 1'b0, 4'd0);
        set_capacity(31);
        send_command(MODE_COMMIT, 32'h8000_0001, 1'b0, 4'd0);
        send_command(MODE_UNDO, 32'h0, 1'b0, 4'd0);
    endtask

    // One phase of random commands under a given capacity.
    task automatic run_random_phase(int count, int cap, bit with_gaps);
        int pick;
        int depth;
        logic [MODE_W-1:0] op;
        logic [WORD_W-1:0] value;
        logic [INDEX_W-1:0] index;
        set_capacity(cap);
        write_register(REG_START, $urandom());
        gaps_enabled = with_gaps;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = MODE_COMMIT;
            else if (pick < 55)
                op = MODE_UNDO;
            else if (pick < 68)
                op = MODE_REDO;
            else if (pick < 78)
                op = MODE_PEEK_UNDO;
            else if (pick < 88)
                op = MODE_PEEK_REDO;
            else if (pick < 92)
                op = MODE_CLEAR;
            else if (pick < 96)
                op = MODE_RESTART;
            else
                op = MODE_UNUSED;

            pick = $urandom_range(0, 9);
            value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();

            // Peeks mostly land near the filled part of the ring.
            depth = model_depth[(op == MODE_PEEK_REDO) ? REDO_RING : UNDO_RING];
            if ($urandom_range(0, 9) < 6)
                index = INDEX_W'($urandom_range(0, (depth > 15) ? 15 : depth));
            else
                index = INDEX_W'($urandom_range(0, 15));

            send_command(op, value, ($urandom_range(0, 99) < 8), index);
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(400, 16, 1'b0);
        run_random_phase(100, 0, 1'b1);
        run_random_phase(150, 1, 1'b1);
        run_random_phase(150, 2, 1'b1);
        run_random_phase(200, 3, 1'b1);
        run_random_phase(250, 31, 1'b1);
        run_random_phase(200, 17, 1'b1);
        run_random_phase(200, $urandom_range(0, 31), 1'b1);
        run_random_phase(200, 5, 1'b1);
        run_random_phase(250, 16, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_history();
        test_commit_and_rollback();
        test_capacity_edges();
        test_random_traffic();
        settle_block();
        repeat (8) @(posedge clk);

        $display("covered %0d commands and %0d result beats over %0d register writes",
                 commands_sent, beats_checked, register_writes);
        $display("capacities from zero to above the ring size, with and without gaps");
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
